// ----- rtl/qsl_pkg.sv -----
// Package: shared tag type for the quicksort sorter
package qsl_pkg;

    typedef struct packed {
        logic last;
    } qsl_tag_t;

endpackage

// ----- rtl/qsl_ram.sv -----
// Generic single-port-write, single-read RAM with registered read
module qsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/qsl_front.sv -----
// Front: input queue of items between the port and the sort engine
module qsl_front
    import qsl_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  qsl_tag_t               in_tag,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic [VALUE_WIDTH-1:0] q_value,
    output qsl_tag_t               q_tag
);

    logic [VALUE_WIDTH-1:0] value_reg [2];
    qsl_tag_t               tag_reg [2];
    logic                   wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_value  = value_reg[rp_reg];
    assign q_tag    = tag_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_reg[wp_reg] <= in_value;
            tag_reg[wp_reg]   <= in_tag;
        end
    end

endmodule

// ----- rtl/qsl_back.sv -----
// Back: store, quicksort engine with range stack, and result emission
module qsl_back
    import qsl_pkg::*;
#(
    parameter int MAX_ITEMS   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [VALUE_WIDTH-1:0] q_value,
    input  qsl_tag_t               q_tag,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic                   out_last,
    output logic                   out_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SD = MAX_ITEMS + 1;
    localparam int SW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_PIV   = 4'd2;
    localparam logic [3:0] S_RDJ   = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_SWF   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_FIN2  = 4'd7;
    localparam logic [3:0] S_PUSH  = 4'd8;
    localparam logic [3:0] S_ERD   = 4'd9;
    localparam logic [3:0] S_EOUT  = 4'd10;
    localparam logic [3:0] S_STK   = 4'd11;
    localparam logic [3:0] S_PUSH2 = 4'd12;

    logic [3:0]             st_reg, st_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   drop_reg, drop_next;
    logic [SPW-1:0]         sp_reg, sp_next;
    logic [AW-1:0]          lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]          j_reg, j_next, f_reg, f_next;
    logic [VALUE_WIDTH-1:0] piv_reg, piv_next, vj_reg, vj_next;
    logic [CW-1:0]          k_reg, k_next;
    logic                   ov_reg, ov_next;
    logic [VALUE_WIDTH-1:0] ov_val_reg, ov_val_next;
    logic                   ov_last_reg, ov_last_next, ov_of_reg, ov_of_next;

    logic                   e_we;
    logic [AW-1:0]          e_wa, e_ra;
    logic [VALUE_WIDTH-1:0] e_wd, e_rd;
    logic                   s_we;
    logic [SW-1:0]          s_wa, s_ra;
    logic [2*AW-1:0]        s_wd, s_rd;

    qsl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_elem (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
    );
    qsl_ram #(.WIDTH(2 * AW), .DEPTH(SD)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
    );

    assign q_ready      = (st_reg == S_LOAD);
    assign out_valid    = ov_reg;
    assign out_value    = ov_val_reg;
    assign out_last     = ov_last_reg;
    assign out_overflow = ov_of_reg;

    always_comb
    begin
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        drop_next    = drop_reg;
        sp_next      = sp_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        f_next       = f_reg;
        piv_next     = piv_reg;
        vj_next      = vj_reg;
        k_next       = k_reg;
        ov_next      = ov_reg && !out_ready;
        ov_val_next  = ov_val_reg;
        ov_last_next = ov_last_reg;
        ov_of_next   = ov_of_reg;
        e_we = 1'b0;
        e_wa = '0;
        e_wd = '0;
        e_ra = '0;
        s_we = 1'b0;
        s_wa = sp_reg[SW-1:0];
        s_wd = '0;
        s_ra = '0;
        unique case (st_reg)
            S_LOAD:
            begin
                if (q_valid)
                begin
                    if (cnt_reg < CW'(MAX_ITEMS))
                    begin
                        e_we     = 1'b1;
                        e_wa     = cnt_reg[AW-1:0];
                        e_wd     = q_value;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (q_tag.last)
                    begin
                        k_next = '0;
                        if (cnt_next >= CW'(2))
                        begin
                            s_we    = 1'b1;
                            s_wa    = '0;
                            s_wd    = {AW'(0), AW'(cnt_next - 1'b1)};
                            sp_next = SPW'(1);
                            st_next = S_POP;
                        end
                        else
                        begin
                            sp_next = '0;
                            st_next = S_ERD;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    st_next = S_ERD;
                end
                else
                begin
                    s_ra    = SW'(sp_reg - 1'b1);
                    sp_next = sp_reg - 1'b1;
                    st_next = S_STK;
                end
            end
            S_STK:
            begin
                lo_next = s_rd[2*AW-1:AW];
                hi_next = s_rd[AW-1:0];
                e_ra    = s_rd[AW-1:0];
                st_next = S_PIV;
            end
            S_PIV:
            begin
                piv_next = e_rd;
                j_next   = lo_reg;
                f_next   = lo_reg;
                e_ra     = lo_reg;
                st_next  = S_RDJ;
            end
            S_RDJ:
            begin
                vj_next = e_rd;
                e_ra    = f_reg;
                st_next = S_CMP;
            end
            S_CMP:
            begin
                if ($signed(vj_reg) <= $signed(piv_reg))
                begin
                    e_we    = 1'b1;
                    e_wa    = j_reg;
                    e_wd    = e_rd;
                    st_next = S_SWF;
                end
                else if (j_reg + 1'b1 == hi_reg)
                begin
                    e_ra    = f_reg;
                    st_next = S_FIN;
                end
                else
                begin
                    j_next  = j_reg + 1'b1;
                    e_ra    = j_reg + 1'b1;
                    st_next = S_RDJ;
                end
            end
            S_SWF:
            begin
                e_we   = 1'b1;
                e_wa   = f_reg;
                e_wd   = vj_reg;
                f_next = f_reg + 1'b1;
                if (j_reg + 1'b1 == hi_reg)
                begin
                    e_ra    = f_reg + 1'b1;
                    st_next = S_FIN;
                end
                else
                begin
                    j_next  = j_reg + 1'b1;
                    e_ra    = j_reg + 1'b1;
                    st_next = S_RDJ;
                end
            end
            S_FIN:
            begin
                e_we    = 1'b1;
                e_wa    = hi_reg;
                e_wd    = e_rd;
                st_next = S_FIN2;
            end
            S_FIN2:
            begin
                e_we    = 1'b1;
                e_wa    = f_reg;
                e_wd    = piv_reg;
                st_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (f_reg > lo_reg && (f_reg - 1'b1) > lo_reg)
                begin
                    s_we    = 1'b1;
                    s_wd    = {lo_reg, AW'(f_reg - 1'b1)};
                    sp_next = sp_reg + 1'b1;
                end
                st_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                if ({1'b0, f_reg} + 1'b1 < {1'b0, hi_reg})
                begin
                    s_we    = 1'b1;
                    s_wd    = {AW'(f_reg + 1'b1), hi_reg};
                    sp_next = sp_reg + 1'b1;
                end
                st_next = S_POP;
            end
            S_ERD:
            begin
                if (k_reg == cnt_reg)
                begin
                    cnt_next  = '0;
                    drop_next = 1'b0;
                    st_next   = S_LOAD;
                end
                else
                begin
                    e_ra    = k_reg[AW-1:0];
                    st_next = S_EOUT;
                end
            end
            S_EOUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next      = 1'b1;
                    ov_val_next  = e_rd;
                    ov_last_next = (k_reg + 1'b1 == cnt_reg);
                    ov_of_next   = drop_reg;
                    k_next       = k_reg + 1'b1;
                    st_next      = S_ERD;
                end
                else
                begin
                    e_ra = k_reg[AW-1:0];
                end
            end
            default:
            begin
                st_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_LOAD;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            sp_reg   <= '0;
            k_reg    <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
            sp_reg   <= sp_next;
            k_reg    <= k_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        j_reg       <= j_next;
        f_reg       <= f_next;
        piv_reg     <= piv_next;
        vj_reg      <= vj_next;
        ov_val_reg  <= ov_val_next;
        ov_last_reg <= ov_last_next;
        ov_of_reg   <= ov_of_next;
    end

endmodule

// ----- rtl/quicksort_lomuto_sorter_core.sv -----
// Top level: quicksort sorter with input queue and sort/emit engine
//  channel | signals                                  | role
//  in      | in_valid in_ready value last             | elements of a run
//  out     | out_valid out_ready value_res last_res overflow | sorted run
// Loading takes one item per cycle. The marked item starts the sort: each
// partition pops a range, moves elements not above its pivot left, places the
// pivot and pushes the subranges. The element RAM has one read and one write
// port with registered read, so a swap takes two writes. Emission reads each
// result, then offers it. Reset clears control; stores need no clearing.
// Output stalls hold the engine; while it sorts or emits, the 2-entry queue fills.
module quicksort_lomuto_sorter_core
    import qsl_pkg::*;
#(
    parameter int MAX_ITEMS   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value_res,
    output logic        last_res,
    output logic        overflow
);

    logic                   q_valid, q_ready;
    logic [VALUE_WIDTH-1:0] q_value, r_value, in_v;
    qsl_tag_t               in_tag, q_tag;

    always_comb
    begin
        in_v = '0;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            in_v[i] = (i < 32) ? value[(i < 32) ? i : 31] : value[31];
        end
        in_tag.last = last;
        value_res = '0;
        for (int i = 0; i < 32; i++)
        begin
            value_res[i] = (i < VALUE_WIDTH) ? r_value[(i < VALUE_WIDTH) ? i : 0]
                                             : r_value[VALUE_WIDTH-1];
        end
    end

    qsl_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_value(in_v), .in_tag(in_tag),
        .q_valid(q_valid), .q_ready(q_ready), .q_value(q_value), .q_tag(q_tag)
    );

    qsl_back #(.MAX_ITEMS(MAX_ITEMS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_value(q_value), .q_tag(q_tag),
        .out_valid(out_valid), .out_ready(out_ready), .out_value(r_value),
        .out_last(last_res), .out_overflow(overflow)
    );

endmodule

// ----- sim/sort_checker.sv -----
// Checker: watches both channels, predicts sorted runs, compares results
`timescale 1ns / 1ps

module sort_checker #(
    parameter int MAX_ITEMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] value,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] value_res,
    input  logic        last_res,
    input  logic        overflow,
    output int          fail_count,
    output int          pending,
    output int          runs_sorted,
    output int          results_seen
);
    typedef struct packed {
        logic [31:0] val;
        logic        fin;
        logic        ovf;
    } sorted_elem_t;

    logic signed [31:0] held[$];
    logic               lost_items;
    sorted_elem_t       sorted_q[$];

    task automatic emit_sorted_run();
        logic signed [31:0] arr[$];
        logic signed [31:0] t;
        int n;
        sorted_elem_t e;
        arr = held;
        n = arr.size();
        for (int i = 1; i < n; i++)
        begin
            t = arr[i];
            for (int j = i - 1; j >= 0; j--)
            begin
                if (arr[j] > t)
                begin
                    arr[j + 1] = arr[j];
                    arr[j] = t;
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            e.val = arr[k];
            e.fin = (k == n - 1);
            e.ovf = lost_items;
            sorted_q.push_back(e);
        end
        held.delete();
        lost_items = 1'b0;
        runs_sorted++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        runs_sorted = 0;
        results_seen = 0;
        lost_items = 1'b0;
    end

    always @(posedge clk)
    begin
        sorted_elem_t exp_e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (sorted_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item value_res=%0d", $time, $signed(value_res));
                end
                else
                begin
                    exp_e = sorted_q.pop_front();
                    if (value_res !== exp_e.val || last_res !== exp_e.fin
                        || overflow !== exp_e.ovf)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected %0d/%b/%b actual %0d/%b/%b", $time,
                                 $signed(exp_e.val), exp_e.fin, exp_e.ovf,
                                 $signed(value_res), last_res, overflow);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (held.size() < MAX_ITEMS)
                    held.push_back(value);
                else
                    lost_items = 1'b1;
                if (last)
                    emit_sorted_run();
            end
        end
        pending = sorted_q.size();
    end
endmodule

// ----- sim/tb_top.sv -----
// Testbench top: drives runs into the quicksort sorter and reports the verdict
`timescale 1ns / 1ps

module tb_top;
    import qsl_pkg::*;

    localparam int MAX_ITEMS = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] value_res;
    logic        last_res;
    logic        overflow;
    int          fail_count;
    int          pending;
    int          runs_sorted;
    int          results_seen;
    int          items_sent;
    int          cycles;
    bit          calm;

    quicksort_lomuto_sorter_core #(.MAX_ITEMS(MAX_ITEMS), .VALUE_WIDTH(32)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .value(value), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .value_res(value_res), .last_res(last_res), .overflow(overflow)
    );

    sort_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .value(value), .last(last),
        .out_valid(out_valid), .out_ready(out_ready), .value_res(value_res),
        .last_res(last_res), .overflow(overflow),
        .fail_count(fail_count), .pending(pending),
        .runs_sorted(runs_sorted), .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver stalls about 12% of cycles, except in calm stretches
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 12);

    task automatic send_item(input logic [31:0] v, input logic l);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        last <= l;
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value(input int mode);
        case (mode)
            0: return $urandom_range(15);
            1: return $urandom_range(7) - 4;
            2: return ($urandom_range(1)) ? 32'h7fffffff - $urandom_range(3)
                                         : 32'h80000000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_run(input int n, input int mode);
        for (int i = 0; i < n; i++)
            send_item(rand_value(mode), i == n - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        cycles = 0;
        items_sent = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        last = 1'b0;
        out_ready = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: single item, extremes, equal values, sorted/reversed
        send_item(32'h0000_0005, 1'b1);
        send_item(32'h7fffffff, 1'b0);
        send_item(32'h80000000, 1'b0);
        send_item(32'h0, 1'b0);
        send_item(32'hffffffff, 1'b0);
        send_item(32'h0000_0001, 1'b1);
        send_item(32'h3, 1'b0);
        send_item(32'h3, 1'b0);
        send_item(32'h3, 1'b1);
        for (int i = 0; i < 5; i++)
            send_item(i, i == 4);
        for (int i = 0; i < 5; i++)
            send_item(-i, i == 4);
        wait_drained();

        // overflow: full store plus extras, last one dropped too
        for (int i = 0; i < MAX_ITEMS + 3; i++)
            send_item($urandom, i == MAX_ITEMS + 2);
        wait_drained();

        calm = 1'b1;
        send_run(MAX_ITEMS, 3);
        wait_drained();
        calm = 1'b0;

        while (items_sent < 470)
        begin
            case ($urandom_range(9))
                0: send_run(MAX_ITEMS + $urandom_range(1, 4), $urandom_range(3));
                1: send_run(MAX_ITEMS, $urandom_range(3));
                2: send_run(1, $urandom_range(3));
                default: send_run($urandom_range(2, 12), $urandom_range(3));
            endcase
            if ($urandom_range(7) == 0)
                wait_drained();
        end
        wait_drained();

        $display("runs sorted: %0d, items sent: %0d, results checked: %0d",
                 runs_sorted, items_sent, results_seen);
        $display("covered extremes, duplicates, single-item runs and overflowed runs");
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/qsl_pkg.sv
rtl/qsl_ram.sv
rtl/qsl_front.sv
rtl/qsl_back.sv
rtl/quicksort_lomuto_sorter_core.sv
sim/sort_checker.sv
sim/tb_top.sv
